// ===== sv/tqm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tqm_pkg
// Shared types and constants of the task ready queue manager.
// ----------------------------------------------------------------------------
package tqm_pkg;

   localparam int NUM_TASKS  = 16;
   localparam int NUM_QUEUES = 8;

   // index widths of the stores
   localparam int TASK_W  = $clog2(NUM_TASKS);
   localparam int QUEUE_W = $clog2(NUM_QUEUES);

   // field widths of the request and the response
   localparam int OP_W    = 3;
   localparam int QID_W   = 3;
   localparam int TID_W   = 4;
   localparam int COUNT_W = 5;

   localparam logic [OP_W-1:0] OP_ADD_TAIL = 3'd0;
   localparam logic [OP_W-1:0] OP_ADD_HEAD = 3'd1;
   localparam logic [OP_W-1:0] OP_INSERT   = 3'd2;
   localparam logic [OP_W-1:0] OP_REMOVE   = 3'd3;
   localparam logic [OP_W-1:0] OP_ROTATE   = 3'd4;

   localparam logic STATUS_DONE   = 1'b0;
   localparam logic STATUS_REJECT = 1'b1;

   typedef struct packed {
      logic [OP_W-1:0]  op;
      logic [QID_W-1:0] queue_id;
      logic [TID_W-1:0] task_id;
      logic [TID_W-1:0] ref_task;
   } req_type;

   typedef struct packed {
      logic               status;
      logic [QID_W-1:0]   affected_queue;
      logic [TID_W-1:0]   head_task;
      logic [COUNT_W-1:0] task_count;
   } rsp_type;

   // one write into a link store (next or prev)
   typedef struct packed {
      logic              en;
      logic [TASK_W-1:0] addr;
      logic [TASK_W-1:0] data;
   } link_wr_type;

   // one write into the owner store
   typedef struct packed {
      logic               en;
      logic [TASK_W-1:0]  addr;
      logic [QUEUE_W-1:0] data;
   } own_wr_type;

   // update of the per-queue table and the membership bits
   typedef struct packed {
      logic               cnt_en;
      logic [QUEUE_W-1:0] queue;
      logic [COUNT_W-1:0] count;
      logic               head_en;
      logic [TASK_W-1:0]  head;
      logic               vld_set;
      logic               vld_clr;
      logic [TASK_W-1:0]  vld_task;
   } qtab_upd_type;

endpackage

// ===== sv/task_ready_queue_manager.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// task_ready_queue_manager
// Circular doubly linked task queues: add, insert, remove and rotate.
// ----------------------------------------------------------------------------
// Once start is taken, busy stays high through the read of the link stores,
// the update and the second link write; the registered response strobe
// follows the second link write, when busy is already low again, so a new
// request may be started in the same cycle as the previous response.
// The second link write is needed because each link store has a single write
// port, which cannot relink both neighbors of a task at once. rsp_strobe is
// high for one cycle only and the receiver cannot stall; a request that finds
// the membership wrong is answered with status reject and changes nothing.
// ----------------------------------------------------------------------------
module task_ready_queue_manager (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  tqm_pkg::req_type req_data,
   output logic             rsp_strobe,
   output tqm_pkg::rsp_type rsp_data
);
   import tqm_pkg::*;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_READ = 2'd1;
   localparam logic [1:0] S_EXEC = 2'd2;
   localparam logic [1:0] S_WR2  = 2'd3;

   logic [1:0]         state_ff, state_in;
   req_type            req_ff;
   logic               ok_ff, ok_in;
   logic [QID_W-1:0]   aq_ff, aq_in;
   link_wr_type        nxt_w2_ff, nxt_w2_in;
   link_wr_type        prv_w2_ff, prv_w2_in;
   logic               rsp_strobe_ff;
   rsp_type            rsp_ff, rsp_in;

   logic [TASK_W-1:0]  rd_addr;
   link_wr_type        next_wr, prev_wr, exe_next_wr, exe_prev_wr;
   own_wr_type         own_wr;
   logic [TASK_W-1:0]  next_rd, prev_rd;
   logic [QUEUE_W-1:0] own_rd;

   logic [QUEUE_W-1:0] qt_queue;
   qtab_upd_type       upd;
   logic [TASK_W-1:0]  head_rd;
   logic [COUNT_W-1:0] count_rd;
   logic               vld_t, vld_r;

   logic [TASK_W-1:0]  t_idx, r_idx;
   logic [QUEUE_W-1:0] qid_idx;
   logic               task_in, ref_in, qid_in;
   logic [COUNT_W-1:0] newc;

   assign t_idx   = req_ff.task_id[TASK_W-1:0];
   assign r_idx   = req_ff.ref_task[TASK_W-1:0];
   assign qid_idx = req_ff.queue_id[QUEUE_W-1:0];
   assign task_in = int'(req_ff.task_id) < NUM_TASKS;
   assign ref_in  = int'(req_ff.ref_task) < NUM_TASKS;
   assign qid_in  = int'(req_ff.queue_id) < NUM_QUEUES;
   assign newc    = (count_rd != '0) ? count_rd - COUNT_W'(1) : '0;

   tqm_links u_links (
      .clock   (clock),
      .rd_addr (rd_addr),
      .next_wr (next_wr),
      .prev_wr (prev_wr),
      .own_wr  (own_wr),
      .next_rd (next_rd),
      .prev_rd (prev_rd),
      .own_rd  (own_rd)
   );

   tqm_qtab u_qtab (
      .clock      (clock),
      .reset      (reset),
      .rd_queue   (qt_queue),
      .vld_a_task (t_idx),
      .vld_b_task (r_idx),
      .upd        (upd),
      .head_rd    (head_rd),
      .count_rd   (count_rd),
      .vld_a      (vld_t),
      .vld_b      (vld_r)
   );

   // link store read address: queue head for add and rotate
   always_comb begin
      case (req_ff.op)
         OP_INSERT: rd_addr = r_idx;
         OP_REMOVE: rd_addr = t_idx;
         default:   rd_addr = head_rd;
      endcase
   end

   // queue table read address follows the step
   always_comb begin
      case (state_ff)
         S_READ:  qt_queue = qid_idx;
         S_EXEC: begin
            if (req_ff.op == OP_INSERT || req_ff.op == OP_REMOVE) begin
               qt_queue = own_rd;
            end else begin
               qt_queue = qid_idx;
            end
         end
         default: qt_queue = aq_ff[QUEUE_W-1:0];
      endcase
   end

   // update step: checks, first link writes and table update
   always_comb begin
      ok_in       = ok_ff;
      aq_in       = aq_ff;
      nxt_w2_in   = nxt_w2_ff;
      prv_w2_in   = prv_w2_ff;
      exe_next_wr = '0;
      exe_prev_wr = '0;
      own_wr      = '0;
      upd         = '0;
      if (state_ff == S_EXEC) begin
         ok_in     = 1'b0;
         aq_in     = req_ff.queue_id;
         nxt_w2_in = '0;
         prv_w2_in = '0;
         case (req_ff.op)
            OP_ADD_TAIL, OP_ADD_HEAD: begin
               if (qid_in && task_in && !vld_t) begin
                  ok_in       = 1'b1;
                  own_wr      = '{en: 1'b1, addr: t_idx, data: qid_idx};
                  upd.cnt_en  = 1'b1;
                  upd.queue   = qid_idx;
                  upd.count   = count_rd + COUNT_W'(1);
                  upd.vld_set = 1'b1;
                  upd.vld_task = t_idx;
                  upd.head    = t_idx;
                  upd.head_en = (req_ff.op == OP_ADD_HEAD) || (count_rd == '0);
                  if (count_rd == '0) begin
                     exe_next_wr = '{en: 1'b1, addr: t_idx, data: t_idx};
                     exe_prev_wr = '{en: 1'b1, addr: t_idx, data: t_idx};
                  end else begin
                     // prev_rd is the old tail
                     exe_next_wr = '{en: 1'b1, addr: t_idx, data: head_rd};
                     exe_prev_wr = '{en: 1'b1, addr: t_idx, data: prev_rd};
                     prv_w2_in   = '{en: 1'b1, addr: head_rd, data: t_idx};
                     nxt_w2_in   = '{en: 1'b1, addr: prev_rd, data: t_idx};
                  end
               end
            end
            OP_INSERT: begin
               if (ref_in && vld_r) begin
                  aq_in = QID_W'(own_rd);
                  if (task_in && !vld_t) begin
                     ok_in        = 1'b1;
                     own_wr       = '{en: 1'b1, addr: t_idx, data: own_rd};
                     upd.cnt_en   = 1'b1;
                     upd.queue    = own_rd;
                     upd.count    = count_rd + COUNT_W'(1);
                     upd.vld_set  = 1'b1;
                     upd.vld_task = t_idx;
                     exe_next_wr  = '{en: 1'b1, addr: t_idx, data: next_rd};
                     exe_prev_wr  = '{en: 1'b1, addr: t_idx, data: r_idx};
                     prv_w2_in    = '{en: 1'b1, addr: next_rd, data: t_idx};
                     nxt_w2_in    = '{en: 1'b1, addr: r_idx, data: t_idx};
                  end
               end
            end
            OP_REMOVE: begin
               if (task_in && vld_t) begin
                  ok_in        = 1'b1;
                  aq_in        = QID_W'(own_rd);
                  upd.cnt_en   = 1'b1;
                  upd.queue    = own_rd;
                  upd.count    = newc;
                  upd.vld_clr  = 1'b1;
                  upd.vld_task = t_idx;
                  upd.head     = next_rd;
                  if (newc != '0) begin
                     exe_prev_wr = '{en: 1'b1, addr: next_rd, data: prev_rd};
                     exe_next_wr = '{en: 1'b1, addr: prev_rd, data: next_rd};
                     upd.head_en = (head_rd == t_idx);
                  end
               end
            end
            OP_ROTATE: begin
               if (qid_in) begin
                  ok_in       = 1'b1;
                  upd.queue   = qid_idx;
                  upd.head    = next_rd;
                  upd.head_en = (count_rd != '0);
               end
            end
            default: begin
               ok_in = 1'b0;
            end
         endcase
      end
   end

   assign next_wr = (state_ff == S_WR2) ? nxt_w2_ff : exe_next_wr;
   assign prev_wr = (state_ff == S_WR2) ? prv_w2_ff : exe_prev_wr;

   // response from the table, already updated by the previous step
   always_comb begin
      rsp_in.status         = ok_ff ? STATUS_DONE : STATUS_REJECT;
      rsp_in.affected_queue = aq_ff;
      if (int'(aq_ff) < NUM_QUEUES && count_rd != '0) begin
         rsp_in.head_task  = TID_W'(head_rd);
         rsp_in.task_count = count_rd;
      end else begin
         rsp_in.head_task  = '0;
         rsp_in.task_count = '0;
      end
   end

   always_comb begin
      case (state_ff)
         S_IDLE:  state_in = start ? S_READ : S_IDLE;
         S_READ:  state_in = S_EXEC;
         S_EXEC:  state_in = S_WR2;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         rsp_strobe_ff <= 1'b0;
         ok_ff         <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_strobe_ff <= (state_ff == S_WR2);
         ok_ff         <= ok_in;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_IDLE && start) begin
         req_ff <= req_data;
      end
      aq_ff     <= aq_in;
      nxt_w2_ff <= nxt_w2_in;
      prv_w2_ff <= prv_w2_in;
      if (state_ff == S_WR2) begin
         rsp_ff <= rsp_in;
      end
   end

   assign busy       = (state_ff != S_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

   a_strobe_after_wr2: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(state_ff) == S_WR2)
      else $error("response strobe without a finished request");

   a_read_after_start: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_READ |-> $past(start) && $past(state_ff) == S_IDLE)
      else $error("request started without a start");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> int'(rsp_data.task_count) <= NUM_TASKS)
      else $error("queue count beyond the number of tasks");

   a_empty_head: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_data.task_count == '0 |-> rsp_data.head_task == '0)
      else $error("empty queue reports a head task");

endmodule

// ===== sv/tqm_links.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tqm_links
// Per-task link stores: next link, previous link and owner queue, each a
// memory with one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module tqm_links (
   input  logic                        clock,
   input  logic [tqm_pkg::TASK_W-1:0]  rd_addr,
   input  tqm_pkg::link_wr_type        next_wr,
   input  tqm_pkg::link_wr_type        prev_wr,
   input  tqm_pkg::own_wr_type         own_wr,
   output logic [tqm_pkg::TASK_W-1:0]  next_rd,
   output logic [tqm_pkg::TASK_W-1:0]  prev_rd,
   output logic [tqm_pkg::QUEUE_W-1:0] own_rd
);
   import tqm_pkg::*;

   logic [TASK_W-1:0]  next_mem [NUM_TASKS];
   logic [TASK_W-1:0]  prev_mem [NUM_TASKS];
   logic [QUEUE_W-1:0] own_mem  [NUM_TASKS];

   logic [TASK_W-1:0]  next_rd_ff;
   logic [TASK_W-1:0]  prev_rd_ff;
   logic [QUEUE_W-1:0] own_rd_ff;

   always_ff @(posedge clock) begin
      if (next_wr.en) begin
         next_mem[next_wr.addr] <= next_wr.data;
      end
      if (prev_wr.en) begin
         prev_mem[prev_wr.addr] <= prev_wr.data;
      end
      if (own_wr.en) begin
         own_mem[own_wr.addr] <= own_wr.data;
      end
      next_rd_ff <= next_mem[rd_addr];
      prev_rd_ff <= prev_mem[rd_addr];
      own_rd_ff  <= own_mem[rd_addr];
   end

   assign next_rd = next_rd_ff;
   assign prev_rd = prev_rd_ff;
   assign own_rd  = own_rd_ff;

endmodule

// ===== sv/tqm_qtab.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tqm_qtab
// Per-queue head and count table plus the per-task membership bits.
// ----------------------------------------------------------------------------
module tqm_qtab (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [tqm_pkg::QUEUE_W-1:0] rd_queue,
   input  logic [tqm_pkg::TASK_W-1:0]  vld_a_task,
   input  logic [tqm_pkg::TASK_W-1:0]  vld_b_task,
   input  tqm_pkg::qtab_upd_type       upd,
   output logic [tqm_pkg::TASK_W-1:0]  head_rd,
   output logic [tqm_pkg::COUNT_W-1:0] count_rd,
   output logic                        vld_a,
   output logic                        vld_b
);
   import tqm_pkg::*;

   logic [TASK_W-1:0]  head_ff  [NUM_QUEUES];
   logic [COUNT_W-1:0] count_ff [NUM_QUEUES];
   logic [NUM_TASKS-1:0] vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_QUEUES; i++) begin
            count_ff[i] <= '0;
            head_ff[i]  <= '0;
         end
         vld_ff <= '0;
      end else begin
         if (upd.cnt_en) begin
            count_ff[upd.queue] <= upd.count;
         end
         if (upd.head_en) begin
            head_ff[upd.queue] <= upd.head;
         end
         if (upd.vld_set) begin
            vld_ff[upd.vld_task] <= 1'b1;
         end else if (upd.vld_clr) begin
            vld_ff[upd.vld_task] <= 1'b0;
         end
      end
   end

   assign head_rd  = head_ff[rd_queue];
   assign count_rd = count_ff[rd_queue];
   assign vld_a    = vld_ff[vld_a_task];
   assign vld_b    = vld_ff[vld_b_task];

endmodule
